// ----- rtl/triangle_phase_residue_top_assert.svh -----
// assertion macros for the triangle phase residue block
`ifndef TRIANGLE_PHASE_RESIDUE_TOP_ASSERT_SVH
`define TRIANGLE_PHASE_RESIDUE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpr: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define TPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpr: next-cycle check failed");

`endif

// ----- rtl/tpr_pkg.sv -----
// shared types and constants for the triangle phase residue block
`default_nettype none

package tpr_pkg;

  // beat kind carried on s_tuser
  typedef enum logic [1:0] {
    FUNC_NODE = 2'd0,
    FUNC_EDGE = 2'd1,
    FUNC_TRI  = 2'd2
  } func_t;

  // vertex pair joined by an edge of the loop p1-p2-p3
  typedef enum logic [1:0] {
    PAIR_12 = 2'd0,
    PAIR_13 = 2'd1,
    PAIR_23 = 2'd2
  } pair_t;

  localparam int SLOT_W   = 12;
  localparam int VTX_W    = 10;
  localparam int EDGE_W   = 12;
  localparam int TIME_W   = 16;
  localparam int COORD_W  = 16;
  localparam int GRAD_W   = 16;
  localparam int RES_W    = 4;
  localparam int S_DATA_W = 144;
  localparam int M_DATA_W = 8;

  localparam int NODE_WORD_W = TIME_W + 2 * COORD_W;
  localparam int EDGE_WORD_W = 2 * VTX_W + GRAD_W;

  // 2*pi in Q3.28; the sum in Q3.12 is scaled by 2^17 before the rounded divide
  localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;
  localparam longint unsigned RND_SCALE  = 64'd131072;

  // |sum| thresholds at which the rounded quotient reaches 1..4
  localparam logic [16:0] RES_TH1 = 17'((1 * TWO_PI_Q28 + RND_SCALE - 1) / RND_SCALE);
  localparam logic [16:0] RES_TH2 = 17'((3 * TWO_PI_Q28 + RND_SCALE - 1) / RND_SCALE);
  localparam logic [16:0] RES_TH3 = 17'((5 * TWO_PI_Q28 + RND_SCALE - 1) / RND_SCALE);
  localparam logic [16:0] RES_TH4 = 17'((7 * TWO_PI_Q28 + RND_SCALE - 1) / RND_SCALE);

endpackage

`default_nettype wire

// ----- rtl/triangle_phase_residue_top.sv -----
// top level of the triangle phase residue block
// a triangle beat passes table read, gradient sum, cross product and output register
// throughput: one beat per cycle when not stalled; node and edge tables are kept in
// three copies each, one read port per vertex and per edge, so a triangle reads all
// six entries at once; load beats write all copies in the accept cycle and give no
// result; reset: rst clears the stage valid bits only; table contents are not cleared
`default_nettype none

`include "triangle_phase_residue_top_assert.svh"

module triangle_phase_residue_top
  import tpr_pkg::*;
#(
  parameter int NODE_COUNT = 1024,
  parameter int EDGE_COUNT = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // slot[11:0] node_time[27:12] node_x[43:28] node_y[59:44] vertex_a[69:60]
  // vertex_b[79:70] vertex_c[89:80] edge_first[101:90] edge_second[113:102]
  // edge_third[125:114] edge_gradient[141:126], zero pad above
  input  logic [S_DATA_W-1:0] s_tdata,
  // func[1:0]
  input  logic [1:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // residue[3:0], zero pad above
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int NAW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int EAW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;

  // input beat fields
  logic [SLOT_W-1:0]  slot;
  logic [TIME_W-1:0]  in_time;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [VTX_W-1:0]   vtx [3];
  logic [EDGE_W-1:0]  edg [3];
  logic [GRAD_W-1:0]  in_grad;

  assign slot    = s_tdata[11:0];
  assign in_time = s_tdata[27:12];
  assign in_x    = s_tdata[43:28];
  assign in_y    = s_tdata[59:44];
  assign vtx[0]  = s_tdata[69:60];
  assign vtx[1]  = s_tdata[79:70];
  assign vtx[2]  = s_tdata[89:80];
  assign edg[0]  = s_tdata[101:90];
  assign edg[1]  = s_tdata[113:102];
  assign edg[2]  = s_tdata[125:114];
  assign in_grad = s_tdata[141:126];

  // stage control
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  logic accept, tri_acc, node_we, edge_we;
  logic [31:0] slot_ext;

  assign en4 = !v4 || m_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  assign accept   = s_tvalid && s_tready;
  assign tri_acc  = accept && (s_tuser == FUNC_TRI);
  assign slot_ext = {20'd0, slot};
  assign node_we  = accept && (s_tuser == FUNC_NODE) && (slot_ext < 32'(NODE_COUNT));
  assign edge_we  = accept && (s_tuser == FUNC_EDGE) && (slot_ext < 32'(EDGE_COUNT));

  // table copies, one read port per triangle vertex and per edge
  logic [NODE_WORD_W-1:0] node_rd [3];
  logic [EDGE_WORD_W-1:0] edge_rd [3];
  logic [31:0]            vtx_ext [3];
  logic [31:0]            edg_ext [3];

  for (genvar k = 0; k < 3; k++) begin : g_tables
    assign vtx_ext[k] = {22'd0, vtx[k]};
    assign edg_ext[k] = {20'd0, edg[k]};

    tpr_ram #(
      .DEPTH (NODE_COUNT),
      .WIDTH (NODE_WORD_W)
    ) u_node_ram (
      .clk   (clk),
      .we    (node_we),
      .waddr (slot_ext[NAW-1:0]),
      .wdata ({in_time, in_x, in_y}),
      .re    (en1),
      .raddr (vtx_ext[k][NAW-1:0]),
      .rdata (node_rd[k])
    );

    tpr_ram #(
      .DEPTH (EDGE_COUNT),
      .WIDTH (EDGE_WORD_W)
    ) u_edge_ram (
      .clk   (clk),
      .we    (edge_we),
      .waddr (slot_ext[EAW-1:0]),
      .wdata ({vtx[0], vtx[1], in_grad}),
      .re    (en1),
      .raddr (edg_ext[k][EAW-1:0]),
      .rdata (edge_rd[k])
    );
  end

  // stage 1: table words arrive, range flags and vertex ids kept beside them
  logic [VTX_W-1:0] p1 [3];
  logic [2:0]       node_ok;
  logic [2:0]       edge_ok;

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < 3; k++) begin
        p1[k]      <= vtx[k];
        node_ok[k] <= vtx_ext[k] < 32'(NODE_COUNT);
        edge_ok[k] <= edg_ext[k] < 32'(EDGE_COUNT);
      end
    end
  end

  // out-of-range indices read as all-zero entries
  logic signed [TIME_W-1:0] t [3];
  logic [COORD_W-1:0]       nx [3];
  logic [COORD_W-1:0]       ny [3];
  logic [VTX_W-1:0]         ea [3];
  logic [VTX_W-1:0]         eb [3];
  logic signed [GRAD_W-1:0] g [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t[k]  = node_ok[k] ? node_rd[k][47:32] : '0;
      nx[k] = node_ok[k] ? node_rd[k][31:16] : '0;
      ny[k] = node_ok[k] ? node_rd[k][15:0]  : '0;
      ea[k] = edge_ok[k] ? edge_rd[k][35:26] : '0;
      eb[k] = edge_ok[k] ? edge_rd[k][25:16] : '0;
      g[k]  = edge_ok[k] ? edge_rd[k][15:0]  : '0;
    end
  end

  // edge classification
  logic  join12, join13, touch_p1, touch_p3;
  pair_t pr [3];

  assign join12   = ((ea[0] == p1[0]) && (eb[0] == p1[1])) ||
                    ((ea[0] == p1[1]) && (eb[0] == p1[0]));
  assign join13   = ((ea[0] == p1[0]) && (eb[0] == p1[2])) ||
                    ((ea[0] == p1[2]) && (eb[0] == p1[0]));
  assign touch_p1 = (ea[1] == p1[0]) || (eb[1] == p1[0]);
  assign touch_p3 = (ea[1] == p1[2]) || (eb[1] == p1[2]);

  always_comb begin
    priority if (join12) begin
      pr[0] = PAIR_12;
      pr[1] = touch_p1 ? PAIR_13 : PAIR_23;
      pr[2] = (pr[1] == PAIR_13) ? PAIR_23 : PAIR_13;
    end else if (join13) begin
      pr[0] = PAIR_13;
      pr[1] = touch_p1 ? PAIR_12 : PAIR_23;
      pr[2] = (pr[1] == PAIR_12) ? PAIR_23 : PAIR_12;
    end else begin
      pr[0] = PAIR_23;
      pr[1] = touch_p3 ? PAIR_13 : PAIR_12;
      pr[2] = (pr[1] == PAIR_13) ? PAIR_12 : PAIR_13;
    end
  end

  // loop direction agrees with time order when the forward end is strictly later
  logic fwd12, fwd13, fwd23;
  logic fwd [3];

  assign fwd12 = t[1] > t[0];
  assign fwd13 = t[0] > t[2];
  assign fwd23 = t[2] > t[1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (pr[k])
        PAIR_12: fwd[k] = fwd12;
        PAIR_13: fwd[k] = fwd13;
        PAIR_23: fwd[k] = fwd23;
        default: fwd[k] = fwd23;
      endcase
    end
  end

  logic signed [17:0] term [3];
  logic signed [17:0] sum_1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term[k] = fwd[k] ? 18'(g[k]) : -18'(g[k]);
    end
    sum_1 = term[0] + term[1] + term[2];
  end

  // stage 2: gradient sum and edge vectors
  logic signed [17:0] sum2;
  logic signed [16:0] dx21, dy32, dy21, dx32;

  always_ff @(posedge clk) begin
    if (en2) begin
      sum2 <= sum_1;
      dx21 <= $signed({1'b0, nx[1]}) - $signed({1'b0, nx[0]});
      dy32 <= $signed({1'b0, ny[2]}) - $signed({1'b0, ny[1]});
      dy21 <= $signed({1'b0, ny[1]}) - $signed({1'b0, ny[0]});
      dx32 <= $signed({1'b0, nx[2]}) - $signed({1'b0, nx[1]});
    end
  end

  // rounded |sum| / 2pi by threshold compare, at most 4
  logic [17:0] mag18;
  logic [16:0] mag;
  logic [2:0]  q_2;

  assign mag18 = sum2[17] ? 18'(-sum2) : 18'(sum2);
  assign mag   = mag18[16:0];
  assign q_2   = 3'(mag >= RES_TH1) + 3'(mag >= RES_TH2) +
                 3'(mag >= RES_TH3) + 3'(mag >= RES_TH4);

  // stage 3: cross product halves
  logic signed [33:0] prod_a, prod_b;
  logic [2:0]         q3;
  logic               sneg3;

  always_ff @(posedge clk) begin
    if (en3) begin
      prod_a <= dx21 * dy32;
      prod_b <= dy21 * dx32;
      q3     <= q_2;
      sneg3  <= sum2[17];
    end
  end

  logic signed [34:0]      cross_z;
  logic                    flip;
  logic signed [RES_W-1:0] res_3;

  assign cross_z = 35'(prod_a) - 35'(prod_b);
  // clockwise loops flip the sign; a zero cross product counts as counterclockwise
  assign flip  = sneg3 ^ cross_z[34];
  assign res_3 = flip ? -$signed({1'b0, q3}) : $signed({1'b0, q3});

  // stage 4: output register
  logic [RES_W-1:0] residue;

  always_ff @(posedge clk) begin
    if (en4) begin
      residue <= res_3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= tri_acc;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {4'd0, residue};

  `TPR_ASSERT_NOW(a_res_range, m_tvalid, ($signed(residue) >= -4'sd4) && ($signed(residue) <= 4'sd4))
  `TPR_ASSERT_NOW(a_stall_source, !s_tready, m_tvalid && !m_tready)
  `TPR_ASSERT_NEXT(a_stage3_hold, v3 && !en3, v3)
  `TPR_ASSERT_NEXT(a_load_silent, s_tvalid && s_tready && (s_tuser != FUNC_TRI), !v1)

endmodule

`default_nettype wire

// ----- rtl/tpr_ram.sv -----
// simple dual-port table memory with registered read data
`default_nettype none

module tpr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for the triangle phase residue block: table loads, loop triangles, residues
module tb;
  import tpr_pkg::*;

  localparam int NODE_COUNT = 1024;
  localparam int EDGE_COUNT = 4096;
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam longint unsigned TWO_PI_FIXED = 64'd1686629713; // 2*pi in Q3.28
  localparam longint unsigned ROUND_SCALE = 64'd131072;      // Q3.12 to Q3.28 plus one bit
  localparam int RANDOM_BEATS = 930;
  localparam int TAIL_CYCLES = 16;
  localparam int IDLE_LIMIT = 2000;

  // s_tdata layout, lowest field last
  typedef struct packed {
    logic [1:0]  pad;
    logic [15:0] edge_gradient;
    logic [11:0] edge_third;
    logic [11:0] edge_second;
    logic [11:0] edge_first;
    logic [9:0]  vertex_c;
    logic [9:0]  vertex_b;
    logic [9:0]  vertex_a;
    logic [15:0] node_y;
    logic [15:0] node_x;
    logic [15:0] node_time;
    logic [11:0] slot;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // predictor copy of the network
  logic [15:0] node_time_mem [NODE_COUNT];
  logic [15:0] node_x_mem [NODE_COUNT];
  logic [15:0] node_y_mem [NODE_COUNT];
  logic [9:0]  edge_a_mem [EDGE_COUNT];
  logic [9:0]  edge_b_mem [EDGE_COUNT];
  logic [15:0] edge_grad_mem [EDGE_COUNT];
  bit node_written [NODE_COUNT];
  bit edge_written [EDGE_COUNT];
  int node_list [$];
  int edge_list [$];

  logic [RES_W-1:0] pending_residues [$];

  int beats_counted = 0;
  int ignored_beats = 0;
  int triangles_sent = 0;
  int residues_checked = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;

  triangle_phase_residue_top #(
    .NODE_COUNT(NODE_COUNT),
    .EDGE_COUNT(EDGE_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap(bit on);
    int roll;
    roll = $urandom_range(0, 99);
    if (!on || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic bit joins(logic [11:0] e, logic [9:0] u, logic [9:0] v);
    return (edge_a_mem[e] == u && edge_b_mem[e] == v) ||
           (edge_a_mem[e] == v && edge_b_mem[e] == u);
  endfunction

  function automatic bit touches(logic [11:0] e, logic [9:0] u);
    return edge_a_mem[e] == u || edge_b_mem[e] == u;
  endfunction

  function automatic logic [RES_W-1:0] triangle_residue(beat_t b);
    pair_t lane [3];
    bit [2:0] fwd;
    logic [11:0] eid [3];
    longint t1, t2, t3, sum, xprod;
    longint unsigned mag, q;
    logic [RES_W-1:0] res;
    eid[0] = b.edge_first;
    eid[1] = b.edge_second;
    eid[2] = b.edge_third;
    // the last edge only ever takes the pair left over
    if (joins(eid[0], b.vertex_a, b.vertex_b)) begin
      lane[0] = PAIR_12;
      lane[1] = touches(eid[1], b.vertex_a) ? PAIR_13 : PAIR_23;
      lane[2] = (lane[1] == PAIR_13) ? PAIR_23 : PAIR_13;
    end else if (joins(eid[0], b.vertex_a, b.vertex_c)) begin
      lane[0] = PAIR_13;
      lane[1] = touches(eid[1], b.vertex_a) ? PAIR_12 : PAIR_23;
      lane[2] = (lane[1] == PAIR_12) ? PAIR_23 : PAIR_12;
    end else begin
      lane[0] = PAIR_23;
      lane[1] = touches(eid[1], b.vertex_c) ? PAIR_13 : PAIR_12;
      lane[2] = (lane[1] == PAIR_13) ? PAIR_12 : PAIR_13;
    end
    t1 = longint'($signed(node_time_mem[b.vertex_a]));
    t2 = longint'($signed(node_time_mem[b.vertex_b]));
    t3 = longint'($signed(node_time_mem[b.vertex_c]));
    fwd[PAIR_12] = t2 > t1;
    fwd[PAIR_13] = t1 > t3;
    fwd[PAIR_23] = t3 > t2;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      if (fwd[lane[k]]) sum += longint'($signed(edge_grad_mem[eid[k]]));
      else sum -= longint'($signed(edge_grad_mem[eid[k]]));
    end
    mag = (sum < 0) ? longint'(-sum) : longint'(sum);
    q = (mag * ROUND_SCALE + TWO_PI_FIXED) / (64'd2 * TWO_PI_FIXED);
    xprod = (longint'(node_x_mem[b.vertex_b]) - longint'(node_x_mem[b.vertex_a])) *
            (longint'(node_y_mem[b.vertex_c]) - longint'(node_y_mem[b.vertex_b])) -
            (longint'(node_y_mem[b.vertex_b]) - longint'(node_y_mem[b.vertex_a])) *
            (longint'(node_x_mem[b.vertex_c]) - longint'(node_x_mem[b.vertex_b]));
    res = q[RES_W-1:0];
    // clockwise loops flip the sign, a zero cross product counts as counterclockwise
    if ((sum < 0) != (xprod < 0)) res = -res;
    return res;
  endfunction

  function automatic void update_network(logic [1:0] f, beat_t b);
    case (f)
      FUNC_NODE: begin
        if (b.slot < NODE_COUNT) begin
          node_time_mem[b.slot] = b.node_time;
          node_x_mem[b.slot] = b.node_x;
          node_y_mem[b.slot] = b.node_y;
          if (!node_written[b.slot]) begin
            node_written[b.slot] = 1'b1;
            node_list.push_back(int'(b.slot));
          end
        end
      end
      FUNC_EDGE: begin
        edge_a_mem[b.slot] = b.vertex_a;
        edge_b_mem[b.slot] = b.vertex_b;
        edge_grad_mem[b.slot] = b.edge_gradient;
        if (!edge_written[b.slot]) begin
          edge_written[b.slot] = 1'b1;
          edge_list.push_back(int'(b.slot));
        end
      end
      FUNC_TRI: pending_residues.push_back(triangle_residue(b));
      default: ;
    endcase
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    b = beat_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    b.pad = '0;
    return b;
  endfunction

  function automatic logic [15:0] rand_time();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return 16'($urandom_range(0, 3));
    if (roll == 3) return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_grad();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 2) return 16'h8000;
    if (roll < 4) return 16'h7fff;
    return 16'($urandom);
  endfunction

  function automatic void shuffle3(ref int a [3]);
    int j, tmp;
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = a[i];
      a[i] = a[j];
      a[j] = tmp;
    end
  endfunction

  // valid stays up across back-to-back beats and drops only before a gap
  task automatic send_beat(logic [1:0] f, beat_t b);
    int gap;
    gap = pick_gap(gaps_on);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= S_DATA_W'(b);
    s_tuser <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    update_network(f, b);
    if (f == FUNC_NONE || (f == FUNC_NODE && b.slot >= NODE_COUNT)) ignored_beats++;
    else beats_counted++;
    if (f == FUNC_TRI) triangles_sent++;
  endtask

  task automatic send_node(int idx, logic [15:0] t, logic [15:0] x, logic [15:0] y);
    beat_t b;
    b = rand_beat();
    b.slot = 12'(idx);
    b.node_time = t;
    b.node_x = x;
    b.node_y = y;
    send_beat(FUNC_NODE, b);
  endtask

  task automatic send_edge(int idx, int a, int c, logic [15:0] g);
    beat_t b;
    b = rand_beat();
    b.slot = 12'(idx);
    b.vertex_a = 10'(a);
    b.vertex_b = 10'(c);
    b.edge_gradient = g;
    send_beat(FUNC_EDGE, b);
  endtask

  task automatic send_triangle(int p1, int p2, int p3, int e1, int e2, int e3);
    beat_t b;
    b = rand_beat();
    b.vertex_a = 10'(p1);
    b.vertex_b = 10'(p2);
    b.vertex_c = 10'(p3);
    b.edge_first = 12'(e1);
    b.edge_second = 12'(e2);
    b.edge_third = 12'(e3);
    send_beat(FUNC_TRI, b);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_residues.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic note_mismatch(string what, logic [RES_W-1:0] want, logic [RES_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected residue %0d, got %0d", what, $signed(want),
               $signed(got));
  endtask

  // residue checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_residues.size() == 0) begin
        note_mismatch("no residue pending", '0, m_tdata[RES_W-1:0]);
      end else begin
        if (m_tdata[RES_W-1:0] !== pending_residues[0])
          note_mismatch("residue", pending_residues[0], m_tdata[RES_W-1:0]);
        void'(pending_residues.pop_front());
        residues_checked++;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      stall_left <= pick_gap(stalls_on);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // extreme times, coordinates and gradients give a full-scale clockwise residue
  task automatic test_table_loads();
    send_node(0, 16'h8000, 16'h0000, 16'h0000);
    send_node(1, 16'h7fff, 16'hffff, 16'hffff);
    send_node(1023, 16'h0000, 16'hffff, 16'h0000);
    send_edge(0, 0, 1, 16'h7fff);
    send_edge(4095, 1023, 1, 16'h8000);
    send_edge(100, 1023, 0, 16'h8000);
    send_triangle(0, 1, 1023, 0, 4095, 100);
  endtask

  // first edge on each vertex pair, middle edge touching the chosen vertex or not
  task automatic test_edge_classification();
    send_triangle(1023, 0, 1, 4095, 100, 0);
    send_triangle(1, 1023, 0, 100, 0, 4095);
    send_triangle(0, 1023, 1, 0, 4095, 100);
    // last edge's endpoints are never looked at, only its gradient
    send_triangle(0, 1, 1023, 0, 4095, 0);
  endtask

  task automatic test_special_cases();
    beat_t b;
    // equal times and collinear nodes
    send_node(2, 16'd7, 16'd100, 16'd100);
    send_node(3, 16'd7, 16'd200, 16'd200);
    send_node(4, 16'd7, 16'd300, 16'd300);
    send_edge(7, 2, 3, 16'h1234);
    send_edge(8, 4, 3, 16'hf000);
    send_edge(9, 4, 2, 16'h3000);
    send_triangle(2, 3, 4, 7, 8, 9);
    // first edge joins none of the pairs
    send_triangle(0, 1, 1023, 7, 0, 4095);
    // node loads past the table must not alias onto low entries
    send_node(1024, 16'h1111, 16'h5555, 16'haaaa);
    send_node(4095, 16'h2222, 16'h1234, 16'h4321);
    send_triangle(0, 1, 1023, 0, 4095, 100);
    b = rand_beat();
    send_beat(FUNC_NONE, b);
    send_triangle(2, 2, 3, 7, 7, 8);
  endtask

  task automatic send_closed_loop();
    int vtx [3];
    int eid [3];
    bit tight;
    vtx[0] = $urandom_range(0, NODE_COUNT - 1);
    do vtx[1] = $urandom_range(0, NODE_COUNT - 1); while (vtx[1] == vtx[0]);
    do vtx[2] = $urandom_range(0, NODE_COUNT - 1);
    while (vtx[2] == vtx[0] || vtx[2] == vtx[1]);
    // a tight box makes zero cross products likely
    tight = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < 3; k++) begin
      if (!node_written[vtx[k]] || $urandom_range(0, 1) == 1)
        send_node(vtx[k], rand_time(),
                  tight ? 16'($urandom_range(0, 2)) : 16'($urandom),
                  tight ? 16'($urandom_range(0, 2)) : 16'($urandom));
    end
    eid[0] = $urandom_range(0, EDGE_COUNT - 1);
    do eid[1] = $urandom_range(0, EDGE_COUNT - 1); while (eid[1] == eid[0]);
    do eid[2] = $urandom_range(0, EDGE_COUNT - 1);
    while (eid[2] == eid[0] || eid[2] == eid[1]);
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 1) == 1) send_edge(eid[k], vtx[k], vtx[(k + 1) % 3], rand_grad());
      else send_edge(eid[k], vtx[(k + 1) % 3], vtx[k], rand_grad());
    end
    repeat ($urandom_range(1, 3)) begin
      shuffle3(vtx);
      shuffle3(eid);
      send_triangle(vtx[0], vtx[1], vtx[2], eid[0], eid[1], eid[2]);
    end
  endtask

  // any written nodes and edges, mostly not a closed loop
  task automatic send_loose_triangle();
    int nn, ne;
    nn = node_list.size() - 1;
    ne = edge_list.size() - 1;
    send_triangle(node_list[$urandom_range(0, nn)], node_list[$urandom_range(0, nn)],
                  node_list[$urandom_range(0, nn)], edge_list[$urandom_range(0, ne)],
                  edge_list[$urandom_range(0, ne)], edge_list[$urandom_range(0, ne)]);
  endtask

  task automatic send_ignored_beat();
    beat_t b;
    b = rand_beat();
    if ($urandom_range(0, 1) == 1) begin
      send_beat(FUNC_NONE, b);
    end else begin
      b.slot = 12'($urandom_range(NODE_COUNT, 4095));
      send_beat(FUNC_NODE, b);
    end
  endtask

  task automatic test_random_triangles();
    int goal, roll;
    bit drained;
    goal = beats_counted + RANDOM_BEATS;
    drained = 1'b0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    while (beats_counted < goal) begin
      if ($urandom_range(0, 49) == 0) gaps_on = !gaps_on;
      if ($urandom_range(0, 49) == 0) stalls_on = !stalls_on;
      if (!drained && beats_counted > goal - RANDOM_BEATS / 2) begin
        wait_drained();
        drained = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) send_closed_loop();
      else if (roll < 90) send_loose_triangle();
      else send_ignored_beat();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_table_loads();
    test_edge_classification();
    test_special_cases();
    wait_drained();
    test_random_triangles();
    wait_drained();
    $display("covered %0d table and triangle beats plus %0d ignored beats",
             beats_counted, ignored_beats);
    $display("%0d triangles evaluated, %0d residues compared, %0d mismatches",
             triangles_sent, residues_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
